// ===== design/prv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prv_pkg
// Shared types, codes and constants for the picture-unit register port.
// ----------------------------------------------------------------------------
`default_nettype none

package prv_pkg;

    localparam int DATA_W        = 8;
    localparam int VADDR_W       = 14;
    localparam int VIDEO_DEPTH   = 1 << VADDR_W;
    localparam int SPRITE_DEPTH  = 256;
    localparam int SPR_ADDR_W    = $clog2(SPRITE_DEPTH);
    localparam int LINE_W        = 10;

    // Transaction kinds on the input channel.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register offsets.
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_MASK     = 4'd1;
    localparam logic [3:0] REG_STATUS   = 4'd2;
    localparam logic [3:0] REG_SPR_ADDR = 4'd3;
    localparam logic [3:0] REG_SPR_DATA = 4'd4;
    localparam logic [3:0] REG_SCROLL   = 4'd5;
    localparam logic [3:0] REG_ADDR     = 4'd6;
    localparam logic [3:0] REG_DATA     = 4'd7;

    // Nametable mirror selections.
    localparam logic [1:0] MIR_NONE = 2'd0;
    localparam logic [1:0] MIR_400  = 2'd1;
    localparam logic [1:0] MIR_800  = 2'd2;

    localparam logic [VADDR_W-1:0] MIR_400_XOR = 14'h0400;
    localparam logic [VADDR_W-1:0] MIR_800_XOR = 14'h0800;
    localparam logic [VADDR_W-1:0] PAL_BASE    = 14'h3F00;
    localparam logic [VADDR_W-1:0] PAL_MASK    = 14'h001F;
    localparam logic [VADDR_W-1:0] PAL_ALIAS   = 14'h0010;
    localparam logic [VADDR_W-1:0] INC_ROW     = 14'd32;
    localparam logic [VADDR_W-1:0] INC_ONE     = 14'd1;

    localparam logic [DATA_W-1:0] UNMAPPED_DATA = 8'hFF;
    localparam logic [DATA_W-1:0] STATUS_RESET  = 8'hA0;
    localparam logic [DATA_W-1:0] STATUS_KEEP   = 8'h3F;

    localparam logic signed [LINE_W-1:0] VBLANK_LINE = 10'sd241;
    localparam logic signed [LINE_W-1:0] WRAP_LINE   = 10'sd262;
    localparam logic signed [LINE_W-1:0] PRE_LINE    = -10'sd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [3:0]        reg_offset;
        logic [DATA_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              nmi_pulse;
    } out_item_t;

    // Palette window folds onto 32 entries; sprite backdrop entries alias
    // onto the background ones.
    function automatic logic [VADDR_W-1:0] map_addr(input logic [VADDR_W-1:0] a);
        logic [VADDR_W-1:0] m;
        m = a;
        if (a >= PAL_BASE)
        begin
            m = PAL_BASE | (a & PAL_MASK);
            if (m[4] && (m[1:0] == 2'b00))
            begin
                m = m - PAL_ALIAS;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/prv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prv_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module prv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== design/ppu_register_port_vram.sv =====
// ----------------------------------------------------------------------------
// ppu_register_port_vram: picture-unit register port with video and sprite memory
// A transaction is accepted in IDLE and finishes in SECOND; its result goes
// to the output register, waiting in HOLD while that register is full. A new
// transaction is taken only in IDLE (a nametable write takes two writes on the single-port video RAM).
// Reset is asynchronous: status returns to 0xA0, the first-read skip is armed
// and the other control registers clear; datapath holding registers and RAMs keep no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppu_register_port_vram (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire prv_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output prv_pkg::out_item_t       out_data
);

    import prv_pkg::*;

    // Sequencer states. A transaction is decoded in IDLE, where the first
    // memory access is issued and the transaction's register updates happen. SECOND
    // collects the registered read data or performs the main video write.
    // HOLD parks a finished result while the output register is still full.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SECOND = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    // Where the read data of the pending transaction comes from.
    localparam logic [1:0] SRC_FIXED  = 2'd0;
    localparam logic [1:0] SRC_SPRITE = 2'd1;
    localparam logic [1:0] SRC_VIDEO  = 2'd2;

    // Control and architectural registers.
    logic [1:0]               state_reg, state_next;
    logic [1:0]               src_reg, src_next;
    logic                     vwr2_reg, vwr2_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               mirror_sel_reg, mirror_sel_next;
    logic [DATA_W-1:0]        control_reg, control_next;
    logic [DATA_W-1:0]        mask_reg, mask_next;
    logic [DATA_W-1:0]        status_reg, status_next;
    logic [SPR_ADDR_W-1:0]    spr_addr_reg, spr_addr_next;
    logic [DATA_W-1:0]        scroll_x_reg, scroll_x_next;
    logic [DATA_W-1:0]        scroll_y_reg, scroll_y_next;
    logic [VADDR_W-1:0]       video_addr_reg, video_addr_next;
    logic [DATA_W-1:0]        hi_latch_reg, hi_latch_next;
    logic                     scroll_tog_reg, scroll_tog_next;
    logic                     addr_tog_reg, addr_tog_next;
    logic                     first_read_reg, first_read_next;
    logic                     ready_flag_reg, ready_flag_next;
    logic signed [LINE_W-1:0] line_reg, line_next;

    // Payload registers.
    out_item_t                fixed_reg, fixed_next;
    out_item_t                hold_reg, hold_next;
    out_item_t                out_data_reg, out_data_next;
    logic [VADDR_W-1:0]       vaddr2_reg, vaddr2_next;
    logic [DATA_W-1:0]        wdata_reg, wdata_next;

    // Memory ports.
    logic                     v_we;
    logic [VADDR_W-1:0]       v_addr;
    logic [DATA_W-1:0]        v_wdata;
    logic [DATA_W-1:0]        v_rdata;
    logic                     s_we;
    logic [DATA_W-1:0]        s_rdata;

    logic                     accept;
    logic                     out_free;
    logic [VADDR_W-1:0]       mirror_xor;
    logic [VADDR_W-1:0]       addr_step;
    logic [VADDR_W-1:0]       main_addr;
    logic signed [LINE_W-1:0] line_inc;
    out_item_t                result;

    prv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VIDEO_DEPTH)
    ) u_video_ram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    prv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SPRITE_DEPTH)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (s_we),
        .addr  (spr_addr_reg),
        .wdata (in_data.write_data),
        .rdata (s_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The data port steps by a whole row when control bit 2 is set.
    assign addr_step = video_addr_reg + (control_reg[2] ? INC_ROW : INC_ONE);
    assign main_addr = map_addr(video_addr_reg);
    assign line_inc  = line_reg + 10'sd1;

    always_comb
    begin
        unique case (mirror_sel_reg)
            MIR_400: mirror_xor = MIR_400_XOR;
            MIR_800: mirror_xor = MIR_800_XOR;
            default: mirror_xor = '0;
        endcase
    end

    // Result of the transaction finishing in SECOND.
    always_comb
    begin
        result = fixed_reg;
        unique case (src_reg)
            SRC_SPRITE: result.read_data = s_rdata;
            SRC_VIDEO:  result.read_data = v_rdata;
            default:    result.read_data = fixed_reg.read_data;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        vwr2_next       = vwr2_reg;
        out_valid_next  = out_valid_reg;
        mirror_sel_next = mirror_sel_reg;
        control_next    = control_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        spr_addr_next   = spr_addr_reg;
        scroll_x_next   = scroll_x_reg;
        scroll_y_next   = scroll_y_reg;
        video_addr_next = video_addr_reg;
        hi_latch_next   = hi_latch_reg;
        scroll_tog_next = scroll_tog_reg;
        addr_tog_next   = addr_tog_reg;
        first_read_next = first_read_reg;
        ready_flag_next = ready_flag_reg;
        line_next       = line_reg;
        fixed_next      = fixed_reg;
        hold_next       = hold_reg;
        out_data_next   = out_data_reg;
        vaddr2_next     = vaddr2_reg;
        wdata_next      = wdata_reg;
        v_we            = 1'b0;
        v_addr          = main_addr;
        v_wdata         = in_data.write_data;
        s_we            = 1'b0;

        if (cfg_valid)
        begin
            mirror_sel_next = cfg_data;
        end

        // The output register drains independently of the sequencer.
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next           = ST_SECOND;
                    src_next             = SRC_FIXED;
                    vwr2_next            = 1'b0;
                    fixed_next.read_data = '0;
                    fixed_next.nmi_pulse = 1'b0;

                    unique case (in_data.op)
                        OP_READ:
                        begin
                            unique case ({1'b0, in_data.reg_offset[2:0]})
                                REG_STATUS:
                                begin
                                    fixed_next.read_data = status_reg;
                                    status_next          = status_reg & STATUS_KEEP;
                                    scroll_tog_next      = 1'b0;
                                    addr_tog_next        = 1'b0;
                                    hi_latch_next        = '0;
                                    first_read_next      = 1'b1;
                                end
                                REG_SPR_DATA:
                                begin
                                    src_next = SRC_SPRITE;
                                end
                                REG_DATA:
                                begin
                                    // The first read after an address change
                                    // does not move the address.
                                    src_next = SRC_VIDEO;
                                    if (first_read_reg)
                                    begin
                                        first_read_next = 1'b0;
                                    end
                                    else
                                    begin
                                        video_addr_next = addr_step;
                                    end
                                end
                                default:
                                begin
                                    fixed_next.read_data = UNMAPPED_DATA;
                                end
                            endcase
                        end

                        OP_WRITE:
                        begin
                            unique case (in_data.reg_offset)
                                REG_CTRL:
                                begin
                                    if (ready_flag_reg)
                                    begin
                                        control_next = in_data.write_data;
                                    end
                                end
                                REG_MASK:
                                begin
                                    if (ready_flag_reg)
                                    begin
                                        mask_next = in_data.write_data;
                                    end
                                end
                                REG_SPR_ADDR:
                                begin
                                    spr_addr_next = in_data.write_data;
                                end
                                REG_SPR_DATA:
                                begin
                                    s_we          = 1'b1;
                                    spr_addr_next = spr_addr_reg + 8'd1;
                                end
                                REG_SCROLL:
                                begin
                                    if (scroll_tog_reg)
                                    begin
                                        scroll_y_next = in_data.write_data;
                                    end
                                    else
                                    begin
                                        scroll_x_next = in_data.write_data;
                                    end
                                    scroll_tog_next = !scroll_tog_reg;
                                end
                                REG_ADDR:
                                begin
                                    if (ready_flag_reg)
                                    begin
                                        if (addr_tog_reg)
                                        begin
                                            video_addr_next = {hi_latch_reg[VADDR_W-9:0],
                                                               in_data.write_data};
                                        end
                                        else
                                        begin
                                            hi_latch_next = in_data.write_data;
                                        end
                                        addr_tog_next   = !addr_tog_reg;
                                        first_read_next = 1'b1;
                                    end
                                end
                                REG_DATA:
                                begin
                                    // Nametable range: the mirror copy goes
                                    // first, the main write follows in SECOND
                                    // so it wins when both land together.
                                    if (video_addr_reg[VADDR_W-1])
                                    begin
                                        v_we   = 1'b1;
                                        v_addr = map_addr(video_addr_reg ^ mirror_xor);
                                    end
                                    vwr2_next       = 1'b1;
                                    vaddr2_next     = main_addr;
                                    wdata_next      = in_data.write_data;
                                    video_addr_next = addr_step;
                                end
                                default:
                                begin
                                end
                            endcase
                        end

                        OP_TICK:
                        begin
                            ready_flag_next = 1'b1;
                            line_next       = line_inc;
                            if (line_inc == VBLANK_LINE)
                            begin
                                status_next          = {1'b1, 1'b0, status_reg[5:0]};
                                fixed_next.nmi_pulse = control_reg[7];
                            end
                            else if (line_inc == WRAP_LINE)
                            begin
                                line_next   = PRE_LINE;
                                status_next = {1'b0, status_reg[6:0]};
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SECOND:
            begin
                if (vwr2_reg)
                begin
                    v_we    = 1'b1;
                    v_addr  = vaddr2_reg;
                    v_wdata = wdata_reg;
                end
                if (out_free)
                begin
                    out_data_next  = result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    hold_next  = result;
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_data_next  = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            src_reg        <= SRC_FIXED;
            vwr2_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            mirror_sel_reg <= MIR_NONE;
            control_reg    <= '0;
            mask_reg       <= '0;
            status_reg     <= STATUS_RESET;
            spr_addr_reg   <= '0;
            scroll_x_reg   <= '0;
            scroll_y_reg   <= '0;
            video_addr_reg <= '0;
            hi_latch_reg   <= '0;
            scroll_tog_reg <= 1'b0;
            addr_tog_reg   <= 1'b0;
            first_read_reg <= 1'b1;
            ready_flag_reg <= 1'b0;
            line_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            src_reg        <= src_next;
            vwr2_reg       <= vwr2_next;
            out_valid_reg  <= out_valid_next;
            mirror_sel_reg <= mirror_sel_next;
            control_reg    <= control_next;
            mask_reg       <= mask_next;
            status_reg     <= status_next;
            spr_addr_reg   <= spr_addr_next;
            scroll_x_reg   <= scroll_x_next;
            scroll_y_reg   <= scroll_y_next;
            video_addr_reg <= video_addr_next;
            hi_latch_reg   <= hi_latch_next;
            scroll_tog_reg <= scroll_tog_next;
            addr_tog_reg   <= addr_tog_next;
            first_read_reg <= first_read_next;
            ready_flag_reg <= ready_flag_next;
            line_reg       <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fixed_reg    <= fixed_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
        vaddr2_reg   <= vaddr2_next;
        wdata_reg    <= wdata_next;
    end

endmodule

`default_nettype wire
